// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define OLIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olir check failed");

// Next-cycle implication, switched off while reset is high.
`define OLIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olir check failed");

`endif

// ----- sv/olir_pkg.sv -----
`default_nettype none

package olir_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W     = 3;
   localparam int ID_W     = 16;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_REVERSE    = 3'd4;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

   // What every cell of the chain does in a cycle.
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type    cmd;
      logic [ID_W-1:0] new_id;
   } cell_ctrl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_id;
      logic [COUNT_W-1:0]  entry_count;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/olir_req_if.sv -----
`default_nettype none

interface olir_req_if;
   logic                       valid;
   logic                       ready;
   logic [olir_pkg::OP_W-1:0]  operation;
   logic [olir_pkg::ID_W-1:0]  item_id;
   logic [olir_pkg::POS_W-1:0] position;

   modport source (output valid, operation, item_id, position, input ready);
   modport sink   (input valid, operation, item_id, position, output ready);
endinterface

`default_nettype wire

// ----- sv/olir_rsp_if.sv -----
`default_nettype none

interface olir_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [olir_pkg::STATUS_W-1:0] status;
   logic [olir_pkg::ID_W-1:0]     out_id;
   logic [olir_pkg::COUNT_W-1:0]  entry_count;
   logic                          last;

   modport source (output valid, status, out_id, entry_count, last, input ready);
   modport sink   (input valid, status, out_id, entry_count, last, output ready);
endinterface

`default_nettype wire

// ----- sv/olir_cell.sv -----
`default_nettype none

// One slot of the list. Insert shifts towards the tail from the selected
// slot on; rotate shifts towards the head up to the selected slot, which
// takes the broadcast identifier.
module olir_cell #(
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  wire                            clock,
   input  olir_pkg::cell_ctrl_type        ctrl,
   input  wire  [IW-1:0]                  sel,
   input  wire  [olir_pkg::ID_W-1:0]      left_data,
   input  wire  [olir_pkg::ID_W-1:0]      right_data,
   output logic [olir_pkg::ID_W-1:0]      data
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [olir_pkg::ID_W-1:0] data_ff;
   logic [olir_pkg::ID_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.cmd)
         olir_pkg::CMD_HOLD: begin
            data_in = data_ff;
         end
         olir_pkg::CMD_INSERT: begin
            if (MY_IDX == sel) begin
               data_in = ctrl.new_id;
            end else if (MY_IDX > sel) begin
               data_in = left_data;
            end
         end
         olir_pkg::CMD_ROTATE: begin
            if (MY_IDX == sel) begin
               data_in = ctrl.new_id;
            end else if (MY_IDX < sel) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- sv/olir_rsp_buf.sv -----
`default_nettype none

// Two-entry result queue: an output register and a skid register behind it.
module olir_rsp_buf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  olir_pkg::rsp_type      push_data,
   output logic                   full,
   olir_rsp_if.source             rsp_ch
);

   logic              v0_ff, v0_in;
   logic              v1_ff, v1_in;
   olir_pkg::rsp_type d0_ff, d0_in;
   olir_pkg::rsp_type d1_ff, d1_in;
   logic              pop;

   always_comb begin
      pop   = v0_ff && rsp_ch.ready;
      v0_in = v0_ff;
      v1_in = v1_ff;
      d0_in = d0_ff;
      d1_in = d1_ff;
      if (pop) begin
         v0_in = v1_ff;
         d0_in = d1_ff;
         v1_in = 1'b0;
      end
      if (push) begin
         if (!v0_in) begin
            v0_in = 1'b1;
            d0_in = push_data;
         end else begin
            v1_in = 1'b1;
            d1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

   assign full               = v1_ff;
   assign rsp_ch.valid       = v0_ff;
   assign rsp_ch.status      = d0_ff.status;
   assign rsp_ch.out_id      = d0_ff.out_id;
   assign rsp_ch.entry_count = d0_ff.entry_count;
   assign rsp_ch.last        = d0_ff.last;

endmodule

`default_nettype wire

// ----- sv/ordered_list_with_insert_and_reverse.sv -----
// An accepted item's result is registered in the result queue that drives the output; a dump
// first enters its dump state. Push, insert and pop are done on acceptance; reverse holds the
// input closed after acceptance, one prefix rotation of the cell chain per cycle, until done.
// A dump gives one item per cycle from the head cell, as the output drains.
// Reset (synchronous, active high) empties the list and the result queue; slot contents
// are left as they are and are only read below the entry count.
`default_nettype none

`include "assert_macros.svh"

module ordered_list_with_insert_and_reverse #(
   parameter int DEPTH = olir_pkg::DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   olir_req_if.sink    req_ch,
   olir_rsp_if.source  rsp_ch
);

   // Index width for a slot, count width for 0..DEPTH, and a compare width
   // that also holds the five-bit insert position.
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REV  = 2'd1;
   localparam logic [1:0] ST_DUMP = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   // In reverse: the last slot of the prefix still to rotate.
   // In dump: how many items remain after the current one.
   logic [CW-1:0] step_ff, step_in;

   olir_pkg::cell_ctrl_type   cell_ctrl;
   logic [IW-1:0]             cell_sel;
   logic [olir_pkg::ID_W-1:0] cell_data [DEPTH];

   logic                          push;
   logic                          buf_full;
   logic [olir_pkg::STATUS_W-1:0] push_status;
   logic [olir_pkg::ID_W-1:0]     push_id;
   logic [CW-1:0]                 push_cnt;
   logic [WW-1:0]                 push_cnt_w;
   logic                          push_last;
   olir_pkg::rsp_type             push_data;

   logic          req_ready_w;
   logic          accept;
   logic [WW-1:0] pos_w;
   logic [WW-1:0] cnt_w;
   logic [CW-1:0] count_m1;
   logic          is_full;

   assign req_ready_w  = (state_ff == ST_IDLE) && !buf_full;
   assign req_ch.ready = req_ready_w;
   assign accept       = req_ch.valid && req_ready_w;

   assign pos_w    = WW'(req_ch.position);
   assign cnt_w    = WW'(count_ff);
   assign count_m1 = count_ff - CW'(1);
   assign is_full  = (count_ff == CW'(DEPTH));

   // Sequencer. Every operation maps onto one of two chain moves: an insert
   // (slots from the chosen one on shift towards the tail) or a rotation of a
   // prefix (slots shift towards the head and the old head drops in at the
   // end of the prefix). Pop is a single rotation of the whole list; reverse
   // is a run of rotations over shrinking prefixes; dump rotates the whole
   // list once per item, reading the head, and so leaves it as it was.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      cell_ctrl.cmd    = olir_pkg::CMD_HOLD;
      cell_ctrl.new_id = req_ch.item_id;
      cell_sel       = '0;
      push           = 1'b0;
      push_status    = olir_pkg::STATUS_OK;
      push_id        = '0;
      push_cnt       = count_ff;
      push_last      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push = 1'b1;
               unique case (req_ch.operation)
                  olir_pkg::OP_PUSH_FRONT,
                  olir_pkg::OP_PUSH_BACK,
                  olir_pkg::OP_INSERT: begin
                     // A bad position is reported ahead of a full list.
                     if (req_ch.operation == olir_pkg::OP_INSERT && pos_w > cnt_w) begin
                        push_status = olir_pkg::STATUS_INVALID;
                     end else if (is_full) begin
                        push_status = olir_pkg::STATUS_FULL;
                     end else begin
                        cell_ctrl.cmd = olir_pkg::CMD_INSERT;
                        if (req_ch.operation == olir_pkg::OP_PUSH_FRONT) begin
                           cell_sel = '0;
                        end else if (req_ch.operation == olir_pkg::OP_PUSH_BACK) begin
                           cell_sel = count_ff[IW-1:0];
                        end else begin
                           cell_sel = pos_w[IW-1:0];
                        end
                        count_in = count_ff + CW'(1);
                        push_cnt = count_ff + CW'(1);
                     end
                  end
                  olir_pkg::OP_POP_FRONT: begin
                     if (count_ff == '0) begin
                        push_status = olir_pkg::STATUS_EMPTY;
                     end else begin
                        cell_ctrl.cmd    = olir_pkg::CMD_ROTATE;
                        cell_ctrl.new_id = cell_data[0];
                        cell_sel         = count_m1[IW-1:0];
                        count_in         = count_m1;
                        push_cnt         = count_m1;
                        push_id          = cell_data[0];
                     end
                  end
                  olir_pkg::OP_REVERSE: begin
                     // The result goes out at once; the input stays closed
                     // until the rotations are done, so order is kept.
                     if (count_ff > CW'(1)) begin
                        state_in = ST_REV;
                        step_in  = count_m1;
                     end
                  end
                  olir_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        push_status = olir_pkg::STATUS_EMPTY;
                     end else begin
                        push     = 1'b0;
                        state_in = ST_DUMP;
                        step_in  = count_m1;
                     end
                  end
                  default: begin
                     push_status = olir_pkg::STATUS_INVALID;
                  end
               endcase
            end
         end
         ST_REV: begin
            cell_ctrl.cmd    = olir_pkg::CMD_ROTATE;
            cell_ctrl.new_id = cell_data[0];
            cell_sel         = step_ff[IW-1:0];
            if (step_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff - CW'(1);
            end
         end
         ST_DUMP: begin
            if (!buf_full) begin
               push             = 1'b1;
               push_id          = cell_data[0];
               push_last        = (step_ff == '0);
               cell_ctrl.cmd    = olir_pkg::CMD_ROTATE;
               cell_ctrl.new_id = cell_data[0];
               cell_sel         = count_m1[IW-1:0];
               if (step_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff - CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The entry count is reported modulo 32.
   assign push_cnt_w = WW'(push_cnt);
   assign push_data  = '{status:      push_status,
                         out_id:      push_id,
                         entry_count: push_cnt_w[olir_pkg::COUNT_W-1:0],
                         last:        push_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
      end
   end

   // The chain of slots. The end slots see their own value on the missing side;
   // the control never selects that path.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      olir_cell #(
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .sel        (cell_sel),
         .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
         .right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
         .data       (cell_data[i])
      );
   end

   olir_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (buf_full),
      .rsp_ch    (rsp_ch)
   );

   // The list never holds more than its depth.
   `OLIR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   // A result is only produced when the queue has room for it.
   `OLIR_ASSERT_NOW(a_no_overflow, clock, reset, push, !buf_full)
   // During a reverse the prefix end stays inside the list and above the head.
   `OLIR_ASSERT_NOW(a_rev_step, clock, reset, state_ff == ST_REV, step_ff != '0 && step_ff < count_ff)
   // A dump leaves the entry count untouched.
   `OLIR_ASSERT_NEXT(a_dump_count, clock, reset, state_ff == ST_DUMP, $stable(count_ff))

endmodule

`default_nettype wire
